@@ src/chunked_bump_allocator_assert.svh @@
// Assertion macros used by the allocator RTL.
`ifndef CHUNKED_BUMP_ALLOCATOR_ASSERT_SVH
`define CHUNKED_BUMP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cba_pkg.sv @@
package cba_pkg;

  localparam int MAX_CHUNKS    = 16;
  localparam int BACKING_BYTES = 65536;
  localparam int PAGE_BYTES    = 4096;
  localparam int ALIGN_LOG2    = 4;
  localparam int ALIGN_BYTES   = 1 << ALIGN_LOG2;

  // Fixed field widths.
  localparam int SIZE_W   = 20;
  localparam int STATUS_W = 2;
  localparam int BADDR_W  = 16;
  localparam int SLOT_W   = 4;

  // Derived widths.
  localparam int IDX_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int COUNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int BASE_W  = $clog2(BACKING_BYTES);
  localparam int LEN_W   = BASE_W + 1;
  localparam int SUM_W   = LEN_W + 1;
  localparam int ASIZE_W = SIZE_W + 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_RELEASED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_OPEN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  used;
  } chunk_t;

  localparam int CHUNK_W = $bits(chunk_t);

  localparam chunk_t RESET_CHUNK = '{
    base:   '0,
    length: LEN_W'(PAGE_BYTES),
    used:   '0
  };

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    chunk_t           wr_entry;
    logic             clear;
  } tbl_req_t;

endpackage

@@ src/cba_if.sv @@
interface cba_req_if;
  import cba_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [SIZE_W-1:0] request_size;

  modport source (output valid, kind, request_size, input ready);
  modport sink   (input valid, kind, request_size, output ready);
endinterface

interface cba_rsp_if;
  import cba_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BADDR_W-1:0]  block_address;
  logic [SLOT_W-1:0]   chunk_slot;
  logic                opened_chunk;

  modport source (output valid, status, block_address, chunk_slot, opened_chunk,
                  input ready);
  modport sink   (input valid, status, block_address, chunk_slot, opened_chunk,
                  output ready);
endinterface

@@ src/cba_ram.sv @@
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/cba_table.sv @@
module cba_table (
  input  logic              clk,
  input  logic              rst,
  input  cba_pkg::tbl_req_t req,
  output cba_pkg::chunk_t   rd_data
);
  import cba_pkg::*;

  logic [CHUNK_W-1:0] ram_q;
  logic               slot0_written;
  logic               rd_fresh0;

  cba_ram #(
    .WIDTH (CHUNK_W),
    .DEPTH (MAX_CHUNKS)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_idx),
    .wdata (req.wr_entry),
    .re    (req.rd_en),
    .raddr (req.rd_idx),
    .rdata (ram_q)
  );

  // Slot 0 reads as the reset chunk until written after reset or release.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      slot0_written <= 1'b0;
    end else if (req.wr_en && req.wr_idx == '0) begin
      slot0_written <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_fresh0 <= (req.rd_idx == '0) && !slot0_written;
    end
  end

  assign rd_data = rd_fresh0 ? RESET_CHUNK : chunk_t'(ram_q);

endmodule

@@ src/chunked_bump_allocator.sv @@
// Arena bump allocator over a 64 KiB backing memory, 16 chunk slots.
// Channels: req (kind, request_size) in, rsp (status, block_address,
// chunk_slot, opened_chunk) out, valid/ready on both; one response per request.
// A request is taken only in the idle state; the block works on one at a time.
// A release or bad-size request goes from the check state straight to done; an
// allocation scans the open slots first fit, and tries to open a new chunk in the
// open state when none fits. The first-fit scan reads one chunk table entry per cycle
// from a single-port-read RAM and compares one entry behind the read, so the
// scan length sets the latency.
// The next request is accepted the cycle after the result enters the output
// register, even if rsp is stalled. A finished result waits in the done state
// until the output register frees up, and no new request is taken meanwhile.
// Reset (and a release request) leaves one empty page chunk at offset 0 and
// the backing pointer at one page; no table clearing pass is needed, slot 0
// reads as its reset value until written.
module chunked_bump_allocator (
  input  logic     clk,
  input  logic     rst,
  cba_req_if.sink  req,
  cba_rsp_if.source rsp
);
  import cba_pkg::*;

  `include "chunked_bump_allocator_assert.svh"

  state_t             state, state_next;
  logic               kind_q;
  logic [SIZE_W-1:0]  size_q;
  logic [LEN_W-1:0]   asize_q;
  logic [COUNT_W-1:0] issue_idx;
  logic               cmp_valid;
  logic [IDX_W-1:0]   cmp_idx;
  logic [COUNT_W-1:0] chunks_open;
  logic [LEN_W-1:0]   backing_top;

  status_t            res_status;
  logic [BADDR_W-1:0] res_addr;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_opened;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [BADDR_W-1:0]  rsp_addr;
  logic [SLOT_W-1:0]   rsp_slot;
  logic                rsp_opened;

  tbl_req_t tbl_req;
  chunk_t   rd_data;

  logic [ASIZE_W-1:0] asize_full;
  logic               bad_size;
  logic               issue_en;
  logic               fit;
  logic               hit;
  logic [LEN_W-1:0]   new_len;
  logic [SUM_W-1:0]   top_sum;
  logic               no_space;
  logic               out_free;

  cba_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  // Size check and alignment.
  assign asize_full = (ASIZE_W'(size_q) + ASIZE_W'(ALIGN_BYTES - 1))
                      & ~ASIZE_W'(ALIGN_BYTES - 1);
  assign bad_size   = (size_q == '0)
                   || (32'(size_q) > 32'(BACKING_BYTES))
                   || (32'(asize_full) > 32'(BACKING_BYTES));

  // Scan: read slot issue_idx, compare slot cmp_idx, whose read was issued in the previous cycle.
  assign issue_en = issue_idx < chunks_open;
  assign fit      = (SUM_W'(rd_data.used) + SUM_W'(asize_q)) <= SUM_W'(rd_data.length);
  assign hit      = cmp_valid && fit;

  // New chunk.
  assign new_len  = (asize_q > LEN_W'(PAGE_BYTES)) ? asize_q : LEN_W'(PAGE_BYTES);
  assign top_sum  = SUM_W'(backing_top) + SUM_W'(new_len);
  assign no_space = (chunks_open >= COUNT_W'(MAX_CHUNKS))
                 || (top_sum > SUM_W'(BACKING_BYTES));

  assign out_free = !rsp_valid || rsp.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (kind_q || bad_size) state_next = S_DONE;
        else                    state_next = S_SCAN;
      end
      S_SCAN: begin
        if (hit)            state_next = S_DONE;
        else if (!issue_en) state_next = S_OPEN;
      end
      S_OPEN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready        = 1'b0;
    tbl_req          = '0;
    tbl_req.rd_idx   = IDX_W'(issue_idx);
    tbl_req.wr_idx   = cmp_idx;
    tbl_req.wr_entry = rd_data;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_CHECK: begin
        tbl_req.clear = kind_q;
      end
      S_SCAN: begin
        tbl_req.rd_en         = issue_en && !hit;
        tbl_req.wr_en         = hit;
        tbl_req.wr_entry.used = LEN_W'(SUM_W'(rd_data.used) + SUM_W'(asize_q));
      end
      S_OPEN: begin
        tbl_req.wr_en    = !no_space;
        tbl_req.wr_idx   = IDX_W'(chunks_open);
        tbl_req.wr_entry = '{
          base:   BASE_W'(backing_top),
          length: new_len,
          used:   asize_q
        };
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chunks_open <= COUNT_W'(1);
      backing_top <= LEN_W'(PAGE_BYTES);
      issue_idx   <= '0;
      cmp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_q <= req.kind;
            size_q <= req.request_size;
          end
        end
        S_CHECK: begin
          asize_q    <= LEN_W'(asize_full);
          issue_idx  <= '0;
          cmp_valid  <= 1'b0;
          res_addr   <= '0;
          res_slot   <= '0;
          res_opened <= 1'b0;
          if (kind_q) begin
            chunks_open <= COUNT_W'(1);
            backing_top <= LEN_W'(PAGE_BYTES);
            res_status  <= ST_RELEASED;
          end else begin
            res_status  <= ST_BAD_SIZE;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_status <= ST_GRANTED;
            res_addr   <= BADDR_W'(SUM_W'(rd_data.base) + SUM_W'(rd_data.used));
            res_slot   <= SLOT_W'(cmp_idx);
            res_opened <= 1'b0;
          end else begin
            cmp_valid <= issue_en;
            cmp_idx   <= IDX_W'(issue_idx);
            if (issue_en) issue_idx <= issue_idx + COUNT_W'(1);
          end
        end
        S_OPEN: begin
          if (no_space) begin
            res_status <= ST_NO_SPACE;
            res_addr   <= '0;
            res_slot   <= '0;
            res_opened <= 1'b0;
          end else begin
            res_status  <= ST_GRANTED;
            res_addr    <= BADDR_W'(backing_top);
            res_slot    <= SLOT_W'(chunks_open);
            res_opened  <= 1'b1;
            backing_top <= LEN_W'(top_sum);
            chunks_open <= chunks_open + COUNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp_status <= res_status;
      rsp_addr   <= res_addr;
      rsp_slot   <= res_slot;
      rsp_opened <= res_opened;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.block_address = rsp_addr;
  assign rsp.chunk_slot    = rsp_slot;
  assign rsp.opened_chunk  = rsp_opened;

  `CBA_ASSERT_NOW(a_open_count_range, clk, rst, 1'b1,
    chunks_open != '0 && 32'(chunks_open) <= MAX_CHUNKS,
    "open chunk count out of range")

  `CBA_ASSERT_NOW(a_backing_top_range, clk, rst, 1'b1,
    32'(backing_top) <= BACKING_BYTES,
    "backing pointer past end of memory")

  `CBA_ASSERT_NEXT(a_open_bumps_count, clk, rst, state == S_OPEN && !no_space,
    chunks_open == $past(chunks_open) + COUNT_W'(1) && res_opened,
    "chunk open did not bump the open count")

  `CBA_ASSERT_NOW(a_table_write_excl, clk, rst, tbl_req.wr_en,
    !tbl_req.rd_en && !tbl_req.clear && (state == S_SCAN || state == S_OPEN),
    "table write overlaps a read or clear")

endmodule

@@ tb/sv/tb_chunked_bump_allocator.sv @@
module tb_chunked_bump_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import cba_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    status_t            status;
    logic [BADDR_W-1:0] addr;
    logic [SLOT_W-1:0]  slot;
    logic               opened;
  } alloc_result_t;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] size;
    logic              fixed;
    alloc_result_t     want;
  } script_row_t;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam alloc_result_t R_NONE = '{ST_GRANTED, 16'd0, 4'd0, 1'b0};
  localparam alloc_result_t R_BAD  = '{ST_BAD_SIZE, 16'd0, 4'd0, 1'b0};
  localparam alloc_result_t R_FULL = '{ST_NO_SPACE, 16'd0, 4'd0, 1'b0};
  localparam alloc_result_t R_REL  = '{ST_RELEASED, 16'd0, 4'd0, 1'b0};
  localparam alloc_result_t R_AT0  = '{ST_GRANTED, 16'd0, 4'd0, 1'b0};

  // fixed = 0 rows are checked against the arena model
  localparam script_row_t SCRIPT [20] = '{
    '{KIND_ALLOC,   20'd0,      1'b1, R_BAD},   // zero size
    '{KIND_ALLOC,   20'hFFFFF,  1'b1, R_BAD},   // largest field value
    '{KIND_ALLOC,   20'd65537,  1'b1, R_BAD},   // one past backing memory
    '{KIND_ALLOC,   20'd65535,  1'b1, R_FULL},  // aligns to whole memory, no room
    '{KIND_ALLOC,   20'd1,      1'b1, R_AT0},
    '{KIND_ALLOC,   20'd17,     1'b0, R_NONE},
    '{KIND_ALLOC,   20'd4048,   1'b0, R_NONE},  // fills page chunk exactly
    '{KIND_ALLOC,   20'd1,      1'b0, R_NONE},  // opens a page chunk
    '{KIND_ALLOC,   20'd8193,   1'b0, R_NONE},  // opens an oversized chunk
    '{KIND_ALLOC,   20'd16,     1'b0, R_NONE},
    '{KIND_RELEASE, 20'hFFFFF,  1'b1, R_REL},
    '{KIND_ALLOC,   20'd65536,  1'b1, R_FULL},
    '{KIND_ALLOC,   20'd61425,  1'b0, R_NONE},  // chunk ends at top of memory
    '{KIND_ALLOC,   20'd4096,   1'b0, R_NONE},
    '{KIND_ALLOC,   20'd16,     1'b1, R_FULL},  // backing memory exhausted
    '{KIND_RELEASE, 20'd0,      1'b1, R_REL},
    '{KIND_ALLOC,   20'hAAAAA,  1'b1, R_BAD},
    '{KIND_ALLOC,   20'h55555,  1'b1, R_BAD},
    '{KIND_ALLOC,   20'h05555,  1'b0, R_NONE},
    '{KIND_ALLOC,   20'h0AAAA,  1'b0, R_NONE}
  };

  logic clk;
  logic rst;

  cba_req_if req ();
  cba_rsp_if rsp ();

  chunked_bump_allocator DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // arena model state
  logic [BASE_W-1:0] arena_base [MAX_CHUNKS];
  logic [LEN_W-1:0]  arena_len  [MAX_CHUNKS];
  logic [LEN_W-1:0]  arena_used [MAX_CHUNKS];
  int unsigned       arena_open;
  logic [LEN_W-1:0]  arena_top;

  alloc_result_t owed_responses [$];
  int            errors;
  int            burst_left;
  logic          use_fixed;
  alloc_result_t fixed_response;
  logic          hold_rsp;
  logic          hold_served;
  int unsigned   cycles;

  function automatic void clear_arena();
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      arena_base[i] = '0;
      arena_len[i]  = '0;
      arena_used[i] = '0;
    end
    arena_len[0] = LEN_W'(PAGE_BYTES);
    arena_open   = 1;
    arena_top    = LEN_W'(PAGE_BYTES);
  endfunction

  function automatic alloc_result_t serve_request(logic kind, logic [SIZE_W-1:0] size);
    alloc_result_t r;
    int unsigned   asize;
    int unsigned   span;
    r = R_BAD;
    if (kind == KIND_RELEASE) begin
      clear_arena();
      r.status = ST_RELEASED;
      return r;
    end
    if (size == 0 || size > BACKING_BYTES) return r;
    asize = (int'(size) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    if (asize > BACKING_BYTES) return r;
    for (int i = 0; i < arena_open; i++) begin
      if (int'(arena_used[i]) + asize <= int'(arena_len[i])) begin
        r = '{ST_GRANTED, BADDR_W'(arena_base[i] + arena_used[i]), SLOT_W'(i), 1'b0};
        arena_used[i] = arena_used[i] + LEN_W'(asize);
        return r;
      end
    end
    span = (asize > PAGE_BYTES) ? asize : PAGE_BYTES;
    if (arena_open >= MAX_CHUNKS || int'(arena_top) + span > BACKING_BYTES) begin
      r.status = ST_NO_SPACE;
      return r;
    end
    arena_base[arena_open] = BASE_W'(arena_top);
    arena_len[arena_open]  = LEN_W'(span);
    arena_used[arena_open] = LEN_W'(asize);
    r = '{ST_GRANTED, BADDR_W'(arena_top), SLOT_W'(arena_open), 1'b1};
    arena_top  = arena_top + LEN_W'(span);
    arena_open = arena_open + 1;
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(int flavor);
    int roll;
    roll = $urandom_range(0, 99);
    case (flavor)
      1: return SIZE_W'($urandom_range(3841, 4096));  // page-sized: walks up the slots
      2: return SIZE_W'($urandom_range(1, 64));
      default: begin
        if (roll < 35) return SIZE_W'($urandom_range(1, 256));
        if (roll < 60) return SIZE_W'($urandom_range(257, 4096));
        if (roll < 75) return SIZE_W'($urandom_range(4097, 20000));
        if (roll < 82) return SIZE_W'($urandom_range(20001, 65536));
        if (roll < 88) return '0;
        if (roll < 94) return SIZE_W'($urandom_range(65537, 1048575));
        return SIZE_W'($urandom);
      end
    endcase
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, want, got);
    end
  endtask

  // starts and ends on a falling edge
  task automatic offer(logic kind, logic [SIZE_W-1:0] size, logic fixed,
                       alloc_result_t want);
    if (burst_left == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req.valid        = 1'b1;
    req.kind         = kind;
    req.request_size = size;
    use_fixed        = fixed;
    fixed_response   = want;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_responses();
    req.valid = 1'b0;
    while (owed_responses.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_chunked_bump_allocator NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin : request_watch
    alloc_result_t predicted;
    if (!rst && req.valid && req.ready) begin
      predicted = serve_request(req.kind, req.request_size);
      owed_responses.push_back(use_fixed ? fixed_response : predicted);
    end
  end

  always @(posedge clk) begin : response_check
    alloc_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (owed_responses.size() == 0) begin
        errors++;
        $display("%0t: response with none expected, expected nothing, actual %0h/%0h/%0h/%0h",
                 $realtime, rsp.status, rsp.block_address, rsp.chunk_slot, rsp.opened_chunk);
      end else begin
        want = owed_responses.pop_front();
        note_mismatch("status", 32'(want.status), 32'(rsp.status));
        note_mismatch("block_address", 32'(want.addr), 32'(rsp.block_address));
        note_mismatch("chunk_slot", 32'(want.slot), 32'(rsp.chunk_slot));
        note_mismatch("opened_chunk", 32'(want.opened), 32'(rsp.opened_chunk));
      end
    end
  end

  // response side: stall patterns that change every so often, plus one long hold
  initial begin : rsp_drain
    int phase_left;
    int style;
    int tick;
    rsp.ready   = 1'b0;
    hold_served = 1'b0;
    phase_left  = 0;
    style       = 0;
    tick        = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_rsp && !hold_served) begin
        hold_served = 1'b1;
        rsp.ready   = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (phase_left == 0) begin
        style      = $urandom_range(0, 3);
        phase_left = $urandom_range(10, 150);
      end
      phase_left--;
      tick++;
      case (style)
        0: rsp.ready = 1'b1;
        1: rsp.ready = ($urandom_range(0, 3) != 0);
        2: rsp.ready = (tick % 5 == 0);
        default: rsp.ready = 1'($urandom_range(0, 1));
      endcase
    end
  end

  initial begin : stimulus
    int sent;
    int flavor;
    int run;
    logic drained;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.kind         = KIND_ALLOC;
    req.request_size = '0;
    use_fixed        = 1'b0;
    fixed_response   = R_NONE;
    hold_rsp         = 1'b0;
    burst_left       = 0;
    sent             = 0;
    drained          = 1'b0;
    clear_arena();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (SCRIPT[i])
      offer(SCRIPT[i].kind, SCRIPT[i].size, SCRIPT[i].fixed, SCRIPT[i].want);
    wait_for_responses();

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1)) begin
        offer(KIND_RELEASE, SIZE_W'($urandom), 1'b0, R_NONE);
        sent++;
      end
      flavor = $urandom_range(0, 9);
      flavor = (flavor < 6) ? 0 : (flavor < 8) ? 1 : 2;
      run    = $urandom_range(5, 40);
      for (int j = 0; j < run && sent < RANDOM_ITEMS; j++) begin
        if (sent >= 150) hold_rsp = 1'b1;
        if (sent >= 400 && !drained) begin
          wait_for_responses();
          drained = 1'b1;
        end
        if (flavor == 0 && $urandom_range(0, 99) < 3)
          offer(KIND_RELEASE, SIZE_W'($urandom), 1'b0, R_NONE);
        else
          offer(KIND_ALLOC, pick_size(flavor), 1'b0, R_NONE);
        sent++;
      end
    end

    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && owed_responses.size() == 0) begin
      $display("tb_chunked_bump_allocator OK");
    end else begin
      $display("tb_chunked_bump_allocator NOT OK");
    end
    $finish;
  end

endmodule
